>>> src/b2da_pkg.sv
// ----------------------------------------------------------------------------
// b2da_pkg
// Shared types and constants for the binary to blanked decimal ASCII block.
// ----------------------------------------------------------------------------
`default_nettype none

package b2da_pkg;

  localparam int WIDE_COUNT   = 5;
  localparam int NARROW_COUNT = 3;
  localparam int QUEUE_DEPTH  = 2;

  localparam logic [5:0] ASCII_ZERO  = 6'h30;
  localparam logic [5:0] ASCII_SPACE = 6'h20;

  // n / 10 == (n * DIV10_MUL) >> DIV10_SHIFT for every 16-bit n
  localparam logic [32:0] DIV10_MUL   = 33'd52429;
  localparam int          DIV10_SHIFT = 19;

  localparam logic [2:0] WIDE_LAST   = 3'(WIDE_COUNT - 1);
  localparam logic [2:0] NARROW_LAST = 3'(NARROW_COUNT - 1);

  typedef struct packed {
    logic [15:0] number;
    logic        mode;
  } in_word_t;

  typedef struct packed {
    logic [5:0] character;
    logic       last;
  } out_word_t;

  typedef struct packed {
    logic [WIDE_COUNT-1:0][5:0] chars;
    logic                       mode;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } push_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

endpackage

`default_nettype wire

>>> src/b2da_front.sv
// ----------------------------------------------------------------------------
// b2da_front
// Accepts a word and peels off one decimal digit a cycle (the last waits for
// queue room), units first, blanking positions above the highest nonzero digit.
// ----------------------------------------------------------------------------
`default_nettype none

module b2da_front
  import b2da_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     start,
  input  wire in_word_t request,
  input  wire q_stat_t  q_stat,
  output logic          busy,
  output push_t         push
);

  typedef enum logic [1:0] {
    F_IDLE = 2'b01,
    F_CONV = 2'b10
  } state_t;

  state_t                      state;
  logic [15:0]                 value;
  logic                        wide;
  logic [2:0]                  pos;
  logic [WIDE_COUNT-1:0][5:0]  chars;

  logic [32:0] prod;
  logic [12:0] quot;
  logic [15:0] times10;
  logic [3:0]  rem;
  logic [5:0]  ch;
  logic [2:0]  last_pos;
  logic        final_step;
  logic        room;
  logic        accept;

  always_comb begin
    prod       = 33'(value) * DIV10_MUL;
    quot       = prod[DIV10_SHIFT+12:DIV10_SHIFT];
    times10    = 16'({quot, 3'b000}) + 16'({quot, 1'b0});
    rem        = 4'(value - times10);
    ch         = (value != 16'd0 || pos == 3'd0) ? ASCII_ZERO + {2'b00, rem} : ASCII_SPACE;
    last_pos   = wide ? WIDE_LAST : NARROW_LAST;
    room       = !q_stat.full;
    final_step = (state == F_CONV) && (pos == last_pos);
    busy       = (state == F_CONV) && !(final_step && room);
    accept     = start && !busy;
    push.valid       = final_step && room;
    push.entry.mode  = wide;
    push.entry.chars = chars;
    push.entry.chars[pos] = ch;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else if (accept) begin
      state <= F_CONV;
    end else if (final_step && room) begin
      state <= F_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      value <= request.mode ? request.number : {8'h00, request.number[7:0]};
      wide  <= request.mode;
      pos   <= 3'd0;
    end else if (state == F_CONV && !final_step) begin
      chars[pos] <= ch;
      value      <= {3'b000, quot};
      pos        <= pos + 3'd1;
    end
  end

endmodule

`default_nettype wire

>>> src/b2da_queue.sv
// ----------------------------------------------------------------------------
// b2da_queue
// Two-entry queue of converted character sets between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module b2da_queue
  import b2da_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire push_t push,
  input  wire logic  pop,
  output entry_t     head,
  output q_stat_t    q_stat
);

  entry_t     entries [QUEUE_DEPTH];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  always_comb begin
    head         = entries[rd_ptr];
    q_stat.empty = (fill == 2'd0);
    q_stat.full  = (fill == 2'(QUEUE_DEPTH));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push.valid) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push.valid, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      entries[wr_ptr] <= push.entry;
    end
  end

endmodule

`default_nettype wire

>>> src/b2da_back.sv
// ----------------------------------------------------------------------------
// b2da_back
// Emits the queued characters, most significant position first, one word
// a cycle, flagging the units character as last.
// ----------------------------------------------------------------------------
`default_nettype none

module b2da_back
  import b2da_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire entry_t  head,
  input  wire q_stat_t q_stat,
  output logic         pop,
  output logic         strobe,
  output out_word_t    result
);

  logic [2:0] k;
  logic [2:0] last_k;
  logic [2:0] sel;

  always_comb begin
    last_k = head.mode ? WIDE_LAST : NARROW_LAST;
    sel    = last_k - k;
    pop    = !q_stat.empty && (k == last_k);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
      k      <= 3'd0;
    end else begin
      strobe <= !q_stat.empty;
      if (pop) begin
        k <= 3'd0;
      end else if (!q_stat.empty) begin
        k <= k + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    result.character <= head.chars[sel];
    result.last      <= pop;
  end

  a_k_bound: assert property (@(posedge clk) disable iff (rst) k <= WIDE_LAST)
    else $error("character index out of range");

  a_narrow_bound: assert property (@(posedge clk) disable iff (rst)
    (!q_stat.empty && !head.mode) |-> (k <= NARROW_LAST))
    else $error("narrow entry indexed past its last position");

  a_last_restart: assert property (@(posedge clk) disable iff (rst)
    pop |=> (strobe && result.last && k == 3'd0))
    else $error("last word not followed by index restart");

endmodule

`default_nettype wire

>>> src/binary_to_decimal_ascii_blanked_top.sv
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii_blanked_top
// Unsigned binary to right-justified, space-blanked decimal ASCII.
//
//   channel  | handshake            | payload
//   ---------+----------------------+---------------------------------
//   request  | start high, busy low | number[15:0], mode
//   result   | strobe, one cycle    | character[5:0], last
//
// Mode 0 gives 3 words, mode 1 gives 5 words; sustained throughput is set
// by the single-word result port and the one digit per cycle divide-by-ten
// unit in the front.
// After acceptance the front converts the digits and queues them, and the back
// registers them out; entries already queued ahead are emitted first.
// Reset clears the front state, the queue and the output strobe.
// The receiver cannot stall; busy is high while the front converts, drops in
// the final digit cycle when the two-entry queue has room, and stays high
// while the queue is full.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_to_decimal_ascii_blanked_top
  import b2da_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     start,
  input  wire in_word_t request,
  output logic          busy,
  output logic          strobe,
  output out_word_t     result
);

  push_t   push;
  q_stat_t q_stat;
  entry_t  head;
  logic    pop;

  b2da_front u_front (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .request (request),
    .q_stat  (q_stat),
    .busy    (busy),
    .push    (push)
  );

  b2da_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .pop    (pop),
    .head   (head),
    .q_stat (q_stat)
  );

  b2da_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .q_stat (q_stat),
    .pop    (pop),
    .strobe (strobe),
    .result (result)
  );

endmodule

`default_nettype wire

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks binary_to_decimal_ascii_blanked_top against an in-bench predictor
// of the blanked decimal text. A short table covers zero, the extremes of
// both widths, ignored upper bits and interior zeros. Random numbers weighted
// toward short values and powers of ten follow. Every character word is
// compared in order against the queue of expected words.
// ----------------------------------------------------------------------------

module testbench;
  import b2da_pkg::*;

  localparam logic MODE_BYTE = 1'b0;
  localparam logic MODE_WORD = 1'b1;

  localparam int DECIMAL_BASE  = 10;
  localparam int RANDOM_ITEMS  = 158;
  localparam int CALM_FIRST    = 60;
  localparam int CALM_LAST     = 110;
  localparam int PAUSE_AT      = 125;
  localparam int DRAIN_CYCLES  = 16;
  localparam int STALL_LIMIT   = 400;
  localparam int REPORT_LIMIT  = 10;
  localparam int TEN_POWERS [WIDE_COUNT] = '{1, 10, 100, 1000, 10000};

  // text is right-justified ASCII, low byte is the units position; 0 = predict
  typedef struct packed {
    logic [15:0] number;
    logic        mode;
    logic [39:0] text;
  } plan_row_t;

  localparam int NUM_ROWS = 22;
  localparam plan_row_t PLAN [NUM_ROWS] = '{
    '{16'd0,     MODE_BYTE, "  0"},
    '{16'd0,     MODE_WORD, "    0"},
    '{16'd255,   MODE_BYTE, "255"},
    '{16'd65535, MODE_WORD, "65535"},
    '{16'hFF00,  MODE_BYTE, "  0"},
    '{16'hFFFF,  MODE_BYTE, "255"},
    '{16'd256,   MODE_BYTE, "  0"},
    '{16'd1,     MODE_BYTE, "  1"},
    '{16'd1,     MODE_WORD, "    1"},
    '{16'd100,   MODE_BYTE, "100"},
    '{16'd10000, MODE_WORD, "10000"},
    '{16'd1001,  MODE_WORD, " 1001"},
    '{16'd10,    MODE_WORD, "   10"},
    '{16'd9,     MODE_BYTE, 40'd0},
    '{16'd99,    MODE_BYTE, 40'd0},
    '{16'd205,   MODE_BYTE, 40'd0},
    '{16'd9999,  MODE_WORD, 40'd0},
    '{16'd40005, MODE_WORD, 40'd0},
    '{16'h8000,  MODE_WORD, 40'd0},
    '{16'h5555,  MODE_WORD, 40'd0},
    '{16'hAAAA,  MODE_BYTE, 40'd0},
    '{16'h7F80,  MODE_WORD, 40'd0}
  };

  logic      clk = 1'b0;
  logic      rst;
  logic      start;
  in_word_t  request;
  logic      busy;
  logic      strobe;
  out_word_t result;

  logic [39:0] typed_text;
  out_word_t   expected_chars[$];
  int          fault_count = 0;
  int          chars_checked = 0;
  int          byte_items = 0;
  int          word_items = 0;
  int          quiet_cycles = 0;

  binary_to_decimal_ascii_blanked_top uut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .request (request),
    .busy    (busy),
    .strobe  (strobe),
    .result  (result)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic void predict_digits(in_word_t req);
    logic [15:0] remain;
    int          width;
    logic [5:0]  glyph [WIDE_COUNT];
    out_word_t   w;
    remain = (req.mode == MODE_WORD) ? req.number : {8'h00, req.number[7:0]};
    width  = (req.mode == MODE_WORD) ? WIDE_COUNT : NARROW_COUNT;
    for (int pos = 0; pos < width; pos++) begin
      if (remain != 16'd0 || pos == 0) begin
        glyph[pos] = ASCII_ZERO + 6'(remain % DECIMAL_BASE);
        remain     = 16'(remain / DECIMAL_BASE);
      end else begin
        glyph[pos] = ASCII_SPACE;
      end
    end
    for (int k = width - 1; k >= 0; k--) begin
      w.character = glyph[k];
      w.last      = (k == 0);
      expected_chars.push_back(w);
    end
  endfunction

  function automatic void queue_text(logic [39:0] text, logic mode);
    int        width;
    out_word_t w;
    width = (mode == MODE_WORD) ? WIDE_COUNT : NARROW_COUNT;
    for (int k = width - 1; k >= 0; k--) begin
      w.character = text[8*k +: 6];
      w.last      = (k == 0);
      expected_chars.push_back(w);
    end
  endfunction

  // acceptance, result check and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) begin
        if (request.mode == MODE_WORD) word_items++;
        else byte_items++;
        if (typed_text != 40'd0) queue_text(typed_text, request.mode);
        else predict_digits(request);
      end
      if (strobe) begin
        if (expected_chars.size() == 0) begin
          fault_count++;
          if (fault_count <= REPORT_LIMIT)
            $display("unexpected word: char %h last %b", result.character, result.last);
        end else begin
          chars_checked++;
          if (result.character !== expected_chars[0].character ||
              result.last !== expected_chars[0].last) begin
            fault_count++;
            if (fault_count <= REPORT_LIMIT)
              $display("word mismatch: expected char %h last %b, got char %h last %b",
                       expected_chars[0].character, expected_chars[0].last,
                       result.character, result.last);
          end
          void'(expected_chars.pop_front());
        end
      end
      if ((start && !busy) || strobe) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
        $display("FAILURE");
        $finish;
      end
    end
  end

  task automatic offer_number(in_word_t w, logic [39:0] text, bit may_idle);
    while (may_idle && $urandom_range(0, 99) < 25) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start      <= 1'b1;
    request    <= w;
    typed_text <= text;
    do @(posedge clk); while (busy);
  endtask

  task automatic hold_until_drained();
    start <= 1'b0;
    @(posedge clk);
    while (expected_chars.size() != 0) @(posedge clk);
  endtask

  initial begin
    in_word_t    w;
    int          pick;
    logic [15:0] value;
    rst        = 1'b1;
    start      = 1'b0;
    request    = '0;
    typed_text = 40'd0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (PLAN[i]) begin
      w.number = PLAN[i].number;
      w.mode   = PLAN[i].mode;
      offer_number(w, PLAN[i].text, 1'b1);
    end
    hold_until_drained();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      w.mode = 1'($urandom_range(0, 1));
      pick   = $urandom_range(0, 3);
      case (pick)
        0: value = 16'($urandom_range(0, 9));
        1: value = 16'($urandom_range(0, 99));
        2: value = 16'(TEN_POWERS[$urandom_range(0, (w.mode == MODE_WORD) ? 4 : 2)]
                       - $urandom_range(0, 1));
        default: value = 16'($urandom);
      endcase
      if (w.mode == MODE_BYTE) value[15:8] = 8'($urandom);
      w.number = value;
      if (n == PAUSE_AT) hold_until_drained();
      offer_number(w, 40'd0, !(n >= CALM_FIRST && n < CALM_LAST));
    end

    start <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Formatted %0d numbers (%0d three-wide, %0d five-wide), %0d characters compared",
             byte_items + word_items, byte_items, word_items, chars_checked);
    $display("Mismatched or unexpected words: %0d", fault_count);
    if (fault_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
